[hw/rtl/can_transceiver_mode_control_unit_defines.svh]
// ---------------------------------------------------------------------------
// CAN transceiver mode control: assertion macros
// Shared concurrent assertion forms for the mode control RTL.
// ---------------------------------------------------------------------------
`ifndef CAN_TRANSCEIVER_MODE_CONTROL_UNIT_DEFINES_SVH
`define CAN_TRANSCEIVER_MODE_CONTROL_UNIT_DEFINES_SVH

// same-cycle implication
`define CANTRCV_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CANTRCV_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/cantrcv_pkg.sv]
// ---------------------------------------------------------------------------
// CAN transceiver mode control package
// Mode, fault, command codes and payload types shared by the RTL.
// ---------------------------------------------------------------------------
package cantrcv_pkg;

   localparam logic [2:0] MODE_NORMAL      = 3'd0;
   localparam logic [2:0] MODE_LISTEN_ONLY = 3'd1;
   localparam logic [2:0] MODE_STANDBY     = 3'd2;
   localparam logic [2:0] MODE_GO_TO_SLEEP = 3'd3;
   localparam logic [2:0] MODE_SLEEP       = 3'd4;

   localparam logic [2:0] FLAG_NONE          = 3'd0;
   localparam logic [2:0] FLAG_BUS_FAILURE   = 3'd1;
   localparam logic [2:0] FLAG_LOCAL_FAILURE = 3'd2;
   localparam logic [2:0] FLAG_POWER_ON      = 3'd3;
   localparam logic [2:0] FLAG_WAKE_UP       = 3'd4;

   localparam logic [1:0] PIN_STATUS_RESET      = 2'd0;
   localparam logic [1:0] PIN_STATUS_SET        = 2'd1;
   localparam logic [1:0] PIN_STATUS_READ_ERROR = 2'd2;

   localparam logic [1:0] WAKE_BY_PIN   = 2'd0;
   localparam logic [1:0] WAKE_BY_BUS   = 2'd2;
   localparam logic [1:0] WAKE_ERROR    = 2'd3;

   typedef enum logic [1:0] {
      CMD_SET_MODE    = 2'd0,
      CMD_GET_MODE    = 2'd1,
      CMD_WAKE_REASON = 2'd2,
      CMD_DIAGNOSE    = 2'd3
   } cmd_type;

   typedef struct packed {
      logic [1:0] command;
      logic [2:0] requested_mode;
      logic [1:0] error_pin_status;
   } req_type;

   typedef struct packed {
      logic       ok;
      logic [2:0] reported_mode;
      logic       standby_pin;
      logic       enable_pin;
      logic       wake_pin;
      logic [2:0] fault_flag;
      logic       flag_is_set;
      logic [1:0] wake_reason;
      logic       wake_callout;
      logic       mode_indication;
   } rsp_type;

endpackage

[hw/rtl/cantrcv_mode_core.sv]
// ---------------------------------------------------------------------------
// CAN transceiver mode core
// Mode/fault state registers and the single-pass command logic.
// ---------------------------------------------------------------------------
`include "can_transceiver_mode_control_unit_defines.svh"

module cantrcv_mode_core
   import cantrcv_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    advance,
   input  logic    interface_ready,
   input  req_type req,
   output rsp_type rsp
);

   logic [2:0] cur_mode_ff, cur_mode_in;
   logic [2:0] prev_mode_ff, prev_mode_in;
   logic [2:0] rep_mode_ff, rep_mode_in;
   logic [2:0] fault_ff, fault_in;
   logic       flag_ff, flag_in;
   logic       stb_ff, stb_in;
   logic       en_ff, en_in;
   logic       wake_ff, wake_in;

   logic       set_accept;
   logic       set_stb, set_en, set_wake;
   logic       ok;
   logic [1:0] reason;
   logic       callout;
   logic       indication;

   always_comb begin
      set_accept = 1'b0;
      set_stb    = stb_ff;
      set_en     = en_ff;
      set_wake   = wake_ff;
      case (req.requested_mode)
         MODE_NORMAL: begin
            set_accept = (cur_mode_ff != MODE_NORMAL);
            set_stb    = 1'b1;
            set_en     = 1'b1;
         end
         MODE_LISTEN_ONLY: begin
            set_accept = (cur_mode_ff != MODE_LISTEN_ONLY);
            set_stb    = 1'b1;
            set_en     = 1'b0;
         end
         MODE_GO_TO_SLEEP: begin
            set_accept = 1'b1;
            set_stb    = 1'b0;
            set_en     = 1'b1;
            set_wake   = 1'b1;
         end
         MODE_STANDBY: begin
            set_accept = (cur_mode_ff != MODE_STANDBY);
            set_stb    = 1'b0;
            set_en     = 1'b0;
         end
         default: begin
            set_accept = 1'b0;
         end
      endcase
   end

   always_comb begin
      cur_mode_in  = cur_mode_ff;
      prev_mode_in = prev_mode_ff;
      rep_mode_in  = rep_mode_ff;
      fault_in     = fault_ff;
      flag_in      = flag_ff;
      stb_in       = stb_ff;
      en_in        = en_ff;
      wake_in      = wake_ff;
      ok           = 1'b0;
      reason       = WAKE_BY_PIN;
      callout      = 1'b0;
      indication   = 1'b0;
      case (req.command)
         CMD_SET_MODE: begin
            if (interface_ready && set_accept) begin
               ok           = 1'b1;
               indication   = 1'b1;
               prev_mode_in = cur_mode_ff;
               cur_mode_in  = req.requested_mode;
               rep_mode_in  = req.requested_mode;
               stb_in       = set_stb;
               en_in        = set_en;
               wake_in      = set_wake;
            end
         end
         CMD_GET_MODE: begin
            ok = interface_ready;
         end
         CMD_WAKE_REASON: begin
            ok          = 1'b1;
            cur_mode_in = rep_mode_ff;
            if (rep_mode_ff == MODE_LISTEN_ONLY) begin
               reason = WAKE_BY_PIN;
            end else if (rep_mode_ff == MODE_STANDBY) begin
               reason = WAKE_BY_BUS;
               if (req.error_pin_status == PIN_STATUS_SET) begin
                  flag_in = 1'b1;
               end else if (req.error_pin_status == PIN_STATUS_RESET) begin
                  flag_in = 1'b0;
               end
            end else begin
               reason = WAKE_ERROR;
            end
         end
         CMD_DIAGNOSE: begin
            if (req.error_pin_status == PIN_STATUS_RESET) begin
               flag_in = 1'b0;
               ok      = 1'b1;
            end else if (req.error_pin_status == PIN_STATUS_SET) begin
               flag_in = 1'b1;
               case (cur_mode_ff)
                  MODE_NORMAL: begin
                     ok = 1'b1;
                     if (prev_mode_ff == MODE_LISTEN_ONLY) begin
                        fault_in = FLAG_WAKE_UP;
                        callout  = 1'b1;
                     end else begin
                        fault_in = FLAG_BUS_FAILURE;
                     end
                  end
                  MODE_LISTEN_ONLY: begin
                     if (prev_mode_ff == MODE_NORMAL) begin
                        fault_in = FLAG_LOCAL_FAILURE;
                        ok       = 1'b1;
                     end else if (prev_mode_ff != MODE_LISTEN_ONLY) begin
                        fault_in = FLAG_POWER_ON;
                        ok       = 1'b1;
                     end
                  end
                  MODE_STANDBY, MODE_GO_TO_SLEEP,
                  MODE_SLEEP: begin
                     ok = 1'b1;
                  end
                  default: begin
                     ok = 1'b0;
                  end
               endcase
            end
         end
         default: begin
            ok = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_mode_ff  <= MODE_STANDBY;
         prev_mode_ff <= MODE_STANDBY;
         rep_mode_ff  <= MODE_STANDBY;
         fault_ff     <= FLAG_NONE;
         flag_ff      <= 1'b0;
         stb_ff       <= 1'b0;
         en_ff        <= 1'b0;
         wake_ff      <= 1'b0;
      end else if (advance) begin
         cur_mode_ff  <= cur_mode_in;
         prev_mode_ff <= prev_mode_in;
         rep_mode_ff  <= rep_mode_in;
         fault_ff     <= fault_in;
         flag_ff      <= flag_in;
         stb_ff       <= stb_in;
         en_ff        <= en_in;
         wake_ff      <= wake_in;
      end
   end

   assign rsp.ok              = ok;
   assign rsp.reported_mode   = rep_mode_in;
   assign rsp.standby_pin     = stb_in;
   assign rsp.enable_pin      = en_in;
   assign rsp.wake_pin        = wake_in;
   assign rsp.fault_flag      = fault_in;
   assign rsp.flag_is_set     = flag_in;
   assign rsp.wake_reason     = reason;
   assign rsp.wake_callout    = callout;
   assign rsp.mode_indication = indication;

   `CANTRCV_ASSERT_NOW(a_ind_needs_ready, advance && indication,
      interface_ready && ok, "mode indication without ready interface")
   `CANTRCV_ASSERT_NEXT(a_set_syncs_modes, advance && indication,
      cur_mode_ff == rep_mode_ff, "current and reported mode differ after set")
   `CANTRCV_ASSERT_NOW(a_callout_flag, advance && callout,
      fault_in == FLAG_WAKE_UP && flag_in, "wake callout without wake-up flag")
   `CANTRCV_ASSERT_NEXT(a_hold_on_stall, !advance,
      $stable(cur_mode_ff) && $stable(fault_ff) && $stable(rep_mode_ff),
      "state moved without a command")

endmodule

[hw/rtl/can_transceiver_mode_control_unit.sv]
// ---------------------------------------------------------------------------
// CAN transceiver mode control unit
// Command register, mode core and response register with valid/ready.
//
//   channel | ports                 | handshake
//   --------+-----------------------+-----------------------
//   command | req_valid/ready/data  | valid/ready transfer
//   result  | rsp_valid/ready/data  | valid/ready transfer
//   config  | csr_write_enable/data | single-cycle write
//
// A command is held in the command register, its result in the result
// register. Throughput: one command per cycle while the result is not
// stalled; mode state updates as the command enters the result register.
// Reset clears all mode state, pins, flags and the ready bit.
// A stalled result holds one command in the command register.
// ---------------------------------------------------------------------------
module can_transceiver_mode_control_unit
   import cantrcv_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data,
   input  logic    csr_write_enable,
   input  logic    csr_write_data
);

   logic    req_valid_ff, req_valid_in;
   req_type req_data_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff;
   logic    ready_ff;
   logic    advance;
   rsp_type core_rsp;

   assign advance      = req_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready    = !req_valid_ff || advance;
   assign req_valid_in = (req_valid && req_ready) || (req_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         ready_ff     <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            ready_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= core_rsp;
      end
   end

   cantrcv_mode_core u_core (
      .clock           (clock),
      .reset           (reset),
      .advance         (advance),
      .interface_ready (ready_ff),
      .req             (req_data_ff),
      .rsp             (core_rsp)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
